[design/qth_pkg.sv]
`default_nettype none

package qth_pkg;

    // Number formats
    localparam int QUAT_FRAC_BITS    = 30;
    localparam int HEADING_FRAC_BITS = 16;
    localparam int ANG_FRAC          = 24;
    localparam int CORDIC_STEPS      = 24;
    localparam int NORM_BITS         = 30;

    // Square root unit sizing: one root bit per stage
    localparam int SQ_STEPS = QUAT_FRAC_BITS + 1;
    localparam int VW       = 2 * SQ_STEPS;
    localparam int REM_W    = SQ_STEPS + 3;

    // CORDIC datapath widths
    localparam int XS_W = NORM_BITS + 1;
    localparam int XY_W = NORM_BITS + 4;
    localparam int Z_W  = ANG_FRAC + 10;
    localparam int SH   = ANG_FRAC - HEADING_FRAC_BITS;
    localparam int H_W  = Z_W - SH + 1;

    localparam logic [63:0] ONE_Q = 64'd1 << (2 * QUAT_FRAC_BITS);
    localparam logic signed [Z_W-1:0] DEG90_Q  = Z_W'(64'd90 << ANG_FRAC);
    localparam logic signed [Z_W-1:0] DEG360_Q = Z_W'(64'd360 << ANG_FRAC);
    localparam logic [H_W-1:0] FULL_H   = H_W'(64'd360 << HEADING_FRAC_BITS);
    localparam logic [Z_W-1:0] ROUND_H  = Z_W'(64'd1 << (SH - 1));

    // Read status codes
    localparam logic [1:0] FIFO_NO_DATA = 2'd2;
    localparam logic [1:0] FIFO_ERROR   = 2'd3;

    // Outcome codes
    localparam logic [2:0] OUT_OK       = 3'd0;
    localparam logic [2:0] OUT_DISABLED = 3'd1;
    localparam logic [2:0] OUT_NO_DATA  = 3'd2;
    localparam logic [2:0] OUT_FIFO_ERR = 3'd3;
    localparam logic [2:0] OUT_NO_QUAT  = 3'd4;
    localparam logic [2:0] OUT_UNCAL    = 3'd5;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        Z_W'(754974720), Z_W'(445687602), Z_W'(235489088), Z_W'(119537938),
        Z_W'(60000934),  Z_W'(30029717),  Z_W'(15018523),  Z_W'(7509720),
        Z_W'(3754917),   Z_W'(1877466),   Z_W'(938734),    Z_W'(469367),
        Z_W'(234684),    Z_W'(117342),    Z_W'(58671),     Z_W'(29335),
        Z_W'(14668),     Z_W'(7334),      Z_W'(3667),      Z_W'(1833),
        Z_W'(917),       Z_W'(458),       Z_W'(229),       Z_W'(115)
    };

    typedef struct packed {
        logic [2:0]  code;
        logic [14:0] acc;
    } side_t;

    // Word context carried alongside the square root
    typedef struct packed {
        logic [63:0]        sx;
        logic [63:0]        b;
        logic signed [63:0] pxy;
        logic signed [31:0] qz;
        side_t              side;
    } sq_car_t;

    // Word context carried through the CORDIC
    typedef struct packed {
        side_t side;
        logic  zero;
    } cd_car_t;

endpackage

`default_nettype wire

[design/qth_front.sv]
`default_nettype none

module qth_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire logic                  enabled,
    input  wire logic [1:0]            fifo_status,
    input  wire logic                  has_quat,
    input  wire logic signed [31:0]    quat_x,
    input  wire logic signed [31:0]    quat_y,
    input  wire logic signed [31:0]    quat_z,
    input  wire logic signed [15:0]    accuracy_raw,
    output logic                       vld_out,
    output logic [qth_pkg::VW-1:0]     v_out,
    output qth_pkg::sq_car_t           car_out
);
    import qth_pkg::*;

    logic               vld1_reg;
    logic [63:0]        sx1_reg, sy1_reg, sz1_reg;
    logic signed [63:0] pxy1_reg;
    logic signed [31:0] qz1_reg;
    side_t              side1_reg;
    side_t              side_next;

    logic               vld2_reg;
    logic [VW-1:0]      v2_reg;
    sq_car_t            car2_reg;

    logic [63:0]        sum_next;
    logic [64:0]        diff_next;

    // Reject checks, in priority order
    always_comb
    begin
        side_next.acc = accuracy_raw[14:0];
        if (!enabled)
            side_next.code = OUT_DISABLED;
        else if (fifo_status == FIFO_NO_DATA)
            side_next.code = OUT_NO_DATA;
        else if (fifo_status == FIFO_ERROR)
            side_next.code = OUT_FIFO_ERR;
        else if (!has_quat)
            side_next.code = OUT_NO_QUAT;
        else if (accuracy_raw[15])
            side_next.code = OUT_UNCAL;
        else
            side_next.code = OUT_OK;
    end

    // Stage 1: squares and cross product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx1_reg   <= 64'(64'(quat_x) * 64'(quat_x));
            sy1_reg   <= 64'(64'(quat_y) * 64'(quat_y));
            sz1_reg   <= 64'(64'(quat_z) * 64'(quat_z));
            pxy1_reg  <= 64'(quat_x) * 64'(quat_y);
            qz1_reg   <= quat_z;
            side1_reg <= side_next;
        end
    end

    // Stage 2: radicand 1 - sum, clamped at zero
    assign sum_next  = sx1_reg + sy1_reg + sz1_reg;
    assign diff_next = {1'b0, ONE_Q} - {1'b0, sum_next};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v2_reg        <= diff_next[64] ? '0 : VW'(diff_next);
            car2_reg.sx   <= sx1_reg;
            car2_reg.b    <= sy1_reg + sz1_reg;
            car2_reg.pxy  <= pxy1_reg;
            car2_reg.qz   <= qz1_reg;
            car2_reg.side <= side1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    assign vld_out = vld2_reg;
    assign v_out   = v2_reg;
    assign car_out = car2_reg;

endmodule

`default_nettype wire

[design/qth_sqrt.sv]
`default_nettype none

module qth_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_vld,
    input  wire logic [qth_pkg::VW-1:0]     v,
    input  wire qth_pkg::sq_car_t           car,
    output logic                            vld_out,
    output logic [qth_pkg::SQ_STEPS-1:0]    root_out,
    output qth_pkg::sq_car_t                car_out
);
    import qth_pkg::*;

    logic                vld_reg  [SQ_STEPS];
    logic [REM_W-1:0]    rem_reg  [SQ_STEPS];
    logic [SQ_STEPS-1:0] root_reg [SQ_STEPS];
    logic [VW-1:0]       v_reg    [SQ_STEPS];
    sq_car_t             car_reg  [SQ_STEPS];

    // One root bit per stage, restoring digit recurrence
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        logic                vld_in;
        logic [REM_W-1:0]    rem_in;
        logic [SQ_STEPS-1:0] root_in;
        logic [VW-1:0]       v_in;
        sq_car_t             car_in;
        logic [REM_W-1:0]    cur;
        logic [REM_W-1:0]    trial;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = v;
            assign car_in  = car;
        end
        else
        begin : g_chain
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign v_in    = v_reg[k-1];
            assign car_in  = car_reg[k-1];
        end

        assign cur   = {rem_in[REM_W-3:0], v_in[VW-1:VW-2]};
        assign trial = REM_W'({root_in, 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cur >= trial)
                begin
                    rem_reg[k]  <= cur - trial;
                    root_reg[k] <= {root_in[SQ_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= cur;
                    root_reg[k] <= {root_in[SQ_STEPS-2:0], 1'b0};
                end
                v_reg[k]   <= {v_in[VW-3:0], 2'b00};
                car_reg[k] <= car_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end
    end

    assign vld_out  = vld_reg[SQ_STEPS-1];
    assign root_out = root_reg[SQ_STEPS-1];
    assign car_out  = car_reg[SQ_STEPS-1];

endmodule

`default_nettype wire

[design/qth_vec.sv]
`default_nettype none

module qth_vec (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_vld,
    input  wire logic [qth_pkg::SQ_STEPS-1:0]  w,
    input  wire qth_pkg::sq_car_t              car,
    output logic                               vld_out,
    output logic signed [qth_pkg::XY_W-1:0]    x_out,
    output logic signed [qth_pkg::XY_W-1:0]    y_out,
    output logic signed [qth_pkg::Z_W-1:0]     z_out,
    output qth_pkg::cd_car_t                   car_out
);
    import qth_pkg::*;

    logic [4:0] vld_reg;

    // Stage 1 regs
    logic [63:0]        sw1_reg, sx1_reg, b1_reg;
    logic signed [63:0] pwz1_reg, pxy1_reg;
    side_t              side1_reg;
    // Stage 2 regs
    logic [63:0]        a2_reg, b2_reg;
    logic signed [63:0] y2_reg;
    side_t              side2_reg;
    // Stage 3 regs
    logic [62:0]        mx3_reg, my3_reg;
    logic               xneg3_reg, yneg3_reg;
    side_t              side3_reg;
    // Stage 4 regs
    logic [62:0]        mx4_reg, my4_reg;
    logic               xneg4_reg, yneg4_reg, zero4_reg;
    logic [5:0]         s4_reg;
    side_t              side4_reg;
    // Stage 5 regs
    logic signed [XY_W-1:0] x5_reg, y5_reg;
    logic signed [Z_W-1:0]  z5_reg;
    cd_car_t                car5_reg;

    logic               xneg_next;
    logic [63:0]        dx_next;
    logic [62:0]        m_next;
    logic [5:0]         msb_next, s_next;
    logic [XS_W-1:0]    xs_next, ys_next;
    logic signed [XY_W-1:0] xa_next, ya_next, x_next, y_next;
    logic signed [Z_W-1:0]  z_next;

    // Stage 1: w squared and w times z
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sw1_reg   <= 64'(64'(w) * 64'(w));
            pwz1_reg  <= $signed(64'(w)) * 64'(car.qz);
            sx1_reg   <= car.sx;
            b1_reg    <= car.b;
            pxy1_reg  <= car.pxy;
            side1_reg <= car.side;
        end
    end

    // Stage 2: atan2 operand sums before the X divide by two
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg    <= sw1_reg + sx1_reg;
            b2_reg    <= b1_reg;
            y2_reg    <= pxy1_reg + pwz1_reg;
            side2_reg <= side1_reg;
        end
    end

    // Stage 3: magnitudes and signs, X truncated toward zero
    assign xneg_next = a2_reg < b2_reg;
    assign dx_next   = xneg_next ? (b2_reg - a2_reg) : (a2_reg - b2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xneg3_reg <= xneg_next;
            mx3_reg   <= 63'(dx_next >> 1);
            yneg3_reg <= y2_reg[63];
            my3_reg   <= y2_reg[63] ? 63'(-y2_reg) : 63'(y2_reg);
            side3_reg <= side2_reg;
        end
    end

    // Stage 4: normalizing shift from the leading one
    assign m_next = mx3_reg | my3_reg;

    always_comb
    begin
        msb_next = '0;
        for (int k = 0; k < 63; k++)
        begin
            if (m_next[k])
                msb_next = 6'(k);
        end
        s_next = (msb_next >= 6'(NORM_BITS)) ? (msb_next - 6'(NORM_BITS - 1)) : 6'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx4_reg   <= mx3_reg;
            my4_reg   <= my3_reg;
            xneg4_reg <= xneg3_reg;
            yneg4_reg <= yneg3_reg;
            zero4_reg <= (m_next == '0);
            s4_reg    <= s_next;
            side4_reg <= side3_reg;
        end
    end

    // Stage 5: scale, restore signs, fold left half-plane by 90 degrees
    assign xs_next = XS_W'(mx4_reg >> s4_reg);
    assign ys_next = XS_W'(my4_reg >> s4_reg);
    assign xa_next = xneg4_reg ? -$signed(XY_W'(xs_next)) : $signed(XY_W'(xs_next));
    assign ya_next = yneg4_reg ? -$signed(XY_W'(ys_next)) : $signed(XY_W'(ys_next));

    always_comb
    begin
        x_next = xa_next;
        y_next = ya_next;
        z_next = '0;
        if (xa_next < 0)
        begin
            if (ya_next >= 0)
            begin
                x_next = ya_next;
                y_next = -xa_next;
                z_next = DEG90_Q;
            end
            else
            begin
                x_next = -ya_next;
                y_next = xa_next;
                z_next = -DEG90_Q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x5_reg        <= x_next;
            y5_reg        <= y_next;
            z5_reg        <= z_next;
            car5_reg.side <= side4_reg;
            car5_reg.zero <= zero4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_vld};
    end

    assign vld_out = vld_reg[4];
    assign x_out   = x5_reg;
    assign y_out   = y5_reg;
    assign z_out   = z5_reg;
    assign car_out = car5_reg;

endmodule

`default_nettype wire

[design/qth_cordic.sv]
`default_nettype none

module qth_cordic (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic signed [qth_pkg::XY_W-1:0] x,
    input  wire logic signed [qth_pkg::XY_W-1:0] y,
    input  wire logic signed [qth_pkg::Z_W-1:0]  z,
    input  wire qth_pkg::cd_car_t            car,
    output logic                             vld_out,
    output logic                             valid_res,
    output logic [2:0]                       outcome,
    output logic [24:0]                      heading_deg,
    output logic [14:0]                      heading_accuracy
);
    import qth_pkg::*;

    logic                  vld_reg [CORDIC_STEPS];
    logic signed [XY_W-1:0] x_reg  [CORDIC_STEPS];
    logic signed [XY_W-1:0] y_reg  [CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg  [CORDIC_STEPS];
    cd_car_t               car_reg [CORDIC_STEPS];

    // Vectoring mode, one micro-rotation per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_rot
        logic                   vld_in;
        logic signed [XY_W-1:0] x_in, y_in, dx, dy;
        logic signed [Z_W-1:0]  z_in;
        cd_car_t                car_in;

        if (k == 0)
        begin : g_first
            assign vld_in = in_vld;
            assign x_in   = x;
            assign y_in   = y;
            assign z_in   = z;
            assign car_in = car;
        end
        else
        begin : g_chain
            assign vld_in = vld_reg[k-1];
            assign x_in   = x_reg[k-1];
            assign y_in   = y_reg[k-1];
            assign z_in   = z_reg[k-1];
            assign car_in = car_reg[k-1];
        end

        assign dx = y_in >>> k;
        assign dy = x_in >>> k;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_in > 0)
                begin
                    x_reg[k] <= x_in + dx;
                    y_reg[k] <= y_in - dy;
                    z_reg[k] <= z_in + ATAN_TAB[k];
                end
                else
                begin
                    x_reg[k] <= x_in - dx;
                    y_reg[k] <= y_in + dy;
                    z_reg[k] <= z_in - ATAN_TAB[k];
                end
                car_reg[k] <= car_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end
    end

    logic                  vldf1_reg, vldf2_reg;
    logic [Z_W-1:0]        zf1_reg;
    cd_car_t               carf1_reg;
    logic signed [Z_W-1:0] zw_next;
    logic [H_W-1:0]        h_next, hw_next;
    logic                  ok_next;

    logic                  res_reg;
    logic [2:0]            code_reg;
    logic [24:0]           head_reg;
    logic [14:0]           acc_reg;

    // Finish 1: wrap negative angles into [0,360)
    assign zw_next = (z_reg[CORDIC_STEPS-1] < 0) ? (z_reg[CORDIC_STEPS-1] + DEG360_Q)
                                                   : z_reg[CORDIC_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zf1_reg   <= (zw_next < 0) ? '0 : Z_W'(zw_next);
            carf1_reg <= car_reg[CORDIC_STEPS-1];
        end
    end

    // Finish 2: round half up, wrap 360 to 0, squash rejected and zero-vector words
    assign h_next  = H_W'((zf1_reg + ROUND_H) >> SH);
    assign hw_next = (h_next >= FULL_H) ? (h_next - FULL_H) : h_next;
    assign ok_next = (carf1_reg.side.code == OUT_OK);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg  <= ok_next;
            code_reg <= carf1_reg.side.code;
            head_reg <= (ok_next && !carf1_reg.zero) ? 25'(hw_next) : '0;
            acc_reg  <= ok_next ? carf1_reg.side.acc : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldf1_reg <= 1'b0;
            vldf2_reg <= 1'b0;
        end
        else if (en)
        begin
            vldf1_reg <= vld_reg[CORDIC_STEPS-1];
            vldf2_reg <= vldf1_reg;
        end
    end

    assign vld_out          = vldf2_reg;
    assign valid_res        = res_reg;
    assign outcome          = code_reg;
    assign heading_deg      = head_reg;
    assign heading_accuracy = acc_reg;

endmodule

`default_nettype wire

[design/quaternion_to_heading.sv]
`default_nettype none

// Yaw heading from one orientation word: rebuilds w = sqrt(1 - x^2 - y^2 - z^2),
// takes atan2(2(xy + wz), w^2 + x^2 - y^2 - z^2) by CORDIC and gives degrees in
// [0,360) with 16 fraction bits. Fully pipelined, one word per cycle unless
// the output word is held: 2 product stages, 31 square root stages, one per root
// bit, 5 operand/normalize stages, 24 CORDIC stages, 2 finishing stages. The
// whole pipe stalls together while the output word is held. Words that fail the
// checks (disabled, no data, read error, no quaternion, negative accuracy) come
// out in order with their outcome code and zero heading and accuracy.
module quaternion_to_heading (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         fifo_status,
    input  wire logic               has_quat,
    input  wire logic signed [31:0] quat_x,
    input  wire logic signed [31:0] quat_y,
    input  wire logic signed [31:0] quat_z,
    input  wire logic signed [15:0] accuracy_raw,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    valid_res,
    output logic [2:0]              outcome,
    output logic [24:0]             heading_deg,
    output logic [14:0]             heading_accuracy
);
    import qth_pkg::*;

    logic          enabled_reg;
    logic          en;

    logic          f_vld;
    logic [VW-1:0] f_v;
    sq_car_t       f_car;

    logic                s_vld;
    logic [SQ_STEPS-1:0] s_root;
    sq_car_t             s_car;

    logic                   v_vld;
    logic signed [XY_W-1:0] v_x, v_y;
    logic signed [Z_W-1:0]  v_z;
    cd_car_t                v_car;

    // Enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enabled_reg <= 1'b0;
        else if (cfg_we)
            enabled_reg <= cfg_data;
    end

    // Pipe advances unless the output word is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    qth_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_vld       (in_valid),
        .enabled      (enabled_reg),
        .fifo_status  (fifo_status),
        .has_quat     (has_quat),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .accuracy_raw (accuracy_raw),
        .vld_out      (f_vld),
        .v_out        (f_v),
        .car_out      (f_car)
    );

    qth_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .v        (f_v),
        .car      (f_car),
        .vld_out  (s_vld),
        .root_out (s_root),
        .car_out  (s_car)
    );

    qth_vec u_vec (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_vld),
        .w       (s_root),
        .car     (s_car),
        .vld_out (v_vld),
        .x_out   (v_x),
        .y_out   (v_y),
        .z_out   (v_z),
        .car_out (v_car)
    );

    qth_cordic u_cordic (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_vld           (v_vld),
        .x                (v_x),
        .y                (v_y),
        .z                (v_z),
        .car              (v_car),
        .vld_out          (out_valid),
        .valid_res        (valid_res),
        .outcome          (outcome),
        .heading_deg      (heading_deg),
        .heading_accuracy (heading_accuracy)
    );

`ifndef NO_ASSERTIONS
    // Result flag agrees with the outcome code
    a_res_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (valid_res == (outcome == OUT_OK)))
        else $error("valid_res disagrees with outcome");

    // Rejected words carry no heading or accuracy
    a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome != OUT_OK) |-> (heading_deg == '0 && heading_accuracy == '0))
        else $error("rejected word has nonzero payload");

    // Heading stays below 360 degrees
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading_deg < 25'(FULL_H)))
        else $error("heading out of range");

    // Disabled block rejects every word it produces, as seen at the front output
    a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (f_vld && !$past(enabled_reg, 2) && $stable(enabled_reg) && $past(en) && $past(en, 2))
            |-> (f_car.side.code == OUT_DISABLED))
        else $error("word passed while disabled");
`endif

endmodule

`default_nettype wire
